/* rtl/core/hba_pkg.sv */
// Package for the heap block allocator: codes, widths, control types and
// the sequencer's control store. No dependencies.
package hba_pkg;

  // Default sizing
  localparam int DEF_MAX_BLOCKS   = 64;
  localparam int DEF_HEADER_BYTES = 8;

  // Field widths
  localparam int CMD_W    = 2;
  localparam int REQ_W    = 24;
  localparam int ADDR_W   = 32;
  localparam int STATUS_W = 3;
  localparam int SIZE_W   = 25;
  localparam int OFF_W    = 32;
  localparam int ENTRY_W  = 1 + SIZE_W + OFF_W;
  localparam int CFG_W    = 32;
  localparam int CFG_IDX_W = 1;

  // Commands
  localparam logic [CMD_W-1:0] CMD_FIRST_FIT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_BEST_FIT  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FREE      = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_REUSED   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_GROWN    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FREED    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BAD_FREE = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_LIMIT = 1'b1;
  localparam logic [31:0] HEAP_LIMIT_RESET = 32'd65536;

  // Sequencer step addresses
  localparam int PC_W = 2;
  localparam logic [PC_W-1:0] PC_IDLE   = 2'd0;
  localparam logic [PC_W-1:0] PC_SCAN   = 2'd1;
  localparam logic [PC_W-1:0] PC_DECIDE = 2'd2;

  // Jump conditions
  localparam logic [1:0] COND_ACCEPT    = 2'd0;
  localparam logic [1:0] COND_SCAN_DONE = 2'd1;
  localparam logic [1:0] COND_SLOT_FREE = 2'd2;

  typedef struct packed {
    logic            take_in;
    logic            scan;
    logic            decide;
    logic [1:0]      cond;
    logic [PC_W-1:0] target;
  } hba_uword_t;

  typedef struct packed {
    logic take_in;
    logic scan;
    logic decide;
  } hba_ctrl_t;

  typedef struct packed {
    logic accept;
    logic scan_done;
    logic slot_free;
  } hba_flags_t;

  // Control store: one word per step, jump to target when cond holds
  function automatic hba_uword_t hba_urom(input logic [PC_W-1:0] pc);
    hba_uword_t w;
    case (pc)
      PC_IDLE:   w = '{take_in: 1'b1, scan: 1'b0, decide: 1'b0,
                       cond: COND_ACCEPT, target: PC_SCAN};
      PC_SCAN:   w = '{take_in: 1'b0, scan: 1'b1, decide: 1'b0,
                       cond: COND_SCAN_DONE, target: PC_DECIDE};
      PC_DECIDE: w = '{take_in: 1'b0, scan: 1'b0, decide: 1'b1,
                       cond: COND_SLOT_FREE, target: PC_IDLE};
      default:   w = '{take_in: 1'b0, scan: 1'b0, decide: 1'b0,
                       cond: COND_SLOT_FREE, target: PC_IDLE};
    endcase
    return w;
  endfunction

endpackage

/* rtl/core/hba_if.sv */
// Item channels of the heap block allocator: request and response.
// Depends on hba_pkg for field widths.
interface hba_req_if;
  import hba_pkg::*;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [REQ_W-1:0]  request_size;
  logic [ADDR_W-1:0] user_address;
  modport source (output valid, command, request_size, user_address, input ready);
  modport sink   (input valid, command, request_size, user_address, output ready);
endinterface

interface hba_rsp_if;
  import hba_pkg::*;
  logic                valid;
  logic                ready;
  logic [ADDR_W-1:0]   result_address;
  logic [STATUS_W-1:0] status;
  modport source (output valid, result_address, status, input ready);
  modport sink   (input valid, result_address, status, output ready);
endinterface

/* rtl/core/heap_block_allocator_top.sv */
// Heap block allocator, first-fit and best-fit, over a table of blocks.
// Requests arrive on req (command, request_size, user_address); one response
// item per request leaves on rsp (result_address, status).
// Configuration: cfg_we with cfg_index 0 writes heap_base, index 1 writes
// heap_limit; write only while the block is idle.
// Sequence: an idle step takes the item, then a scan of the block table
// reads one entry per cycle from a single-port-read RAM (a first fit or
// free hit stops the scan sooner, an empty table ends it without a read),
// then a decide step writes back and loads the output register.
// The next request is taken while the previous response still waits in the
// output register; if the receiver stalls, the decide step holds until the
// output register is free.
// Reset clears the block count, heap usage, registers (heap_limit to 65536)
// and the output valid; the table RAM needs no clearing.
// Depends on hba_pkg, hba_if, hba_ram and hba_seq.
module heap_block_allocator_top
  import hba_pkg::*;
#(
  parameter int MAX_BLOCKS   = DEF_MAX_BLOCKS,
  parameter int HEADER_BYTES = DEF_HEADER_BYTES
) (
  input  logic                 clk,
  input  logic                 rst,
  hba_req_if.sink              req,
  hba_rsp_if.source            rsp,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);
  localparam int AW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);

  hba_ctrl_t  ctrl;
  hba_flags_t flags;

  // Architectural state
  logic [31:0]      heap_base;
  logic [31:0]      heap_limit;
  logic [31:0]      heap_used;
  logic [CW-1:0]    count;

  // Request held during the scan
  logic [CMD_W-1:0]  cmd_q;
  logic [SIZE_W-1:0] total_q;
  logic [ADDR_W-1:0] uaddr_q;
  logic [ADDR_W-1:0] base_hdr_q;

  // Scan state
  logic [CW-1:0]     rd_idx;
  logic              pend;
  logic [AW-1:0]     pend_idx;
  logic              found;
  logic [AW-1:0]     pick_idx;
  logic [OFF_W-1:0]  pick_off;
  logic [SIZE_W-1:0] pick_size;
  logic [SIZE_W-1:0] best_spare;

  // Output register
  logic                out_valid;
  logic [ADDR_W-1:0]   out_addr;
  logic [STATUS_W-1:0] out_status;

  // Table RAM ports
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic [ENTRY_W-1:0] wr_data;
  logic               rd_en;
  logic [ENTRY_W-1:0] rd_data;

  // Combinational scan and decide terms
  logic              accept;
  logic              is_alloc;
  logic              is_best;
  logic              is_free;
  logic              issue;
  logic              e_free;
  logic [SIZE_W-1:0] e_size;
  logic [OFF_W-1:0]  e_off;
  logic [SIZE_W-1:0] spare;
  logic              fit;
  logic              take;
  logic              slot_free;
  logic              go;
  logic [32:0]       grow_sum;
  logic              refuse;
  logic              grow;
  logic [ADDR_W-1:0]   dec_addr;
  logic [STATUS_W-1:0] dec_status;

  hba_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .ctrl  (ctrl)
  );

  hba_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_BLOCKS)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_idx[AW-1:0]),
    .rd_data (rd_data)
  );

  assign req.ready = ctrl.take_in;
  assign accept    = req.valid & req.ready;
  assign slot_free = ~out_valid | rsp.ready;
  assign go        = ctrl.decide & slot_free;

  // Command decode
  assign is_alloc = (cmd_q == CMD_FIRST_FIT) || (cmd_q == CMD_BEST_FIT);
  assign is_best  = (cmd_q == CMD_BEST_FIT);
  assign is_free  = (cmd_q == CMD_FREE);

  // Evaluate the entry read in the previous cycle
  always_comb begin
    e_free = rd_data[ENTRY_W-1];
    e_size = rd_data[OFF_W +: SIZE_W];
    e_off  = rd_data[OFF_W-1:0];
    fit    = e_free && (e_size >= total_q);
    spare  = e_size - total_q;
    take   = pend && ((is_alloc && fit && (!found || (is_best && spare < best_spare))) ||
                      (is_free && ((base_hdr_q + e_off) == uaddr_q)));
    issue  = (is_alloc || is_free) && (rd_idx < count);
    rd_en  = ctrl.scan && issue;
    flags.accept    = accept;
    flags.scan_done = (take && !is_best) || (!issue && !pend);
    flags.slot_free = slot_free;
  end

  // Decide: reuse, append, mark free or refuse
  always_comb begin
    grow_sum   = {1'b0, heap_used} + 33'(total_q);
    refuse     = (count == CW'(MAX_BLOCKS)) || (grow_sum > {1'b0, heap_limit});
    grow       = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = pick_idx;
    wr_data    = {1'b0, pick_size, pick_off};
    dec_addr   = '0;
    dec_status = ST_BAD_FREE;
    if (is_alloc) begin
      if (found) begin
        wr_en      = go;
        dec_addr   = base_hdr_q + pick_off;
        dec_status = ST_REUSED;
      end else if (refuse) begin
        dec_status = ST_NO_SPACE;
      end else begin
        grow       = go;
        wr_en      = go;
        wr_addr    = count[AW-1:0];
        wr_data    = {1'b0, total_q, heap_used};
        dec_addr   = base_hdr_q + heap_used;
        dec_status = ST_GROWN;
      end
    end else if (is_free && found) begin
      wr_en      = go;
      wr_data    = {1'b1, pick_size, pick_off};
      dec_status = ST_FREED;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      heap_base  <= '0;
      heap_limit <= HEAP_LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HEAP_BASE:  heap_base  <= cfg_wdata;
        CFG_HEAP_LIMIT: heap_limit <= cfg_wdata;
        default:        ;
      endcase
    end
  end

  // Heap growth
  always_ff @(posedge clk) begin
    if (rst) begin
      heap_used <= '0;
      count     <= '0;
    end else if (grow) begin
      heap_used <= heap_used + 32'(total_q);
      count     <= count + CW'(1);
    end
  end

  // Take the item and start the scan
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q      <= req.command;
      total_q    <= {1'b0, req.request_size} + SIZE_W'(HEADER_BYTES);
      uaddr_q    <= req.user_address;
      base_hdr_q <= heap_base + 32'(HEADER_BYTES);
    end
  end

  // Walk the table, one read per cycle, and hold the best pick
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx <= '0;
      pend   <= 1'b0;
      found  <= 1'b0;
    end else if (accept) begin
      rd_idx <= '0;
      pend   <= 1'b0;
      found  <= 1'b0;
    end else if (ctrl.scan) begin
      pend <= issue;
      if (issue) begin
        rd_idx <= rd_idx + CW'(1);
      end
      if (take) begin
        found <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.scan) begin
      pend_idx <= rd_idx[AW-1:0];
      if (take) begin
        pick_idx   <= pend_idx;
        pick_off   <= e_off;
        pick_size  <= e_size;
        best_spare <= spare;
      end
    end
  end

  // Output register: load on decide, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (go) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_addr   <= dec_addr;
      out_status <= dec_status;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.result_address = out_addr;
  assign rsp.status         = out_status;
endmodule

/* rtl/core/hba_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write and read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule

/* rtl/core/hba_seq.sv */
// Microcoded sequencer: step counter, control store lookup and jumps.
// Depends on hba_pkg for the control store and control types.
module hba_seq
  import hba_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  hba_flags_t flags,
  output hba_ctrl_t  ctrl
);
  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  hba_uword_t      uw;
  logic            jump;

  assign uw = hba_urom(pc);

  // Decode the current control word
  always_comb begin
    ctrl.take_in = uw.take_in;
    ctrl.scan    = uw.scan;
    ctrl.decide  = uw.decide;
    case (uw.cond)
      COND_ACCEPT:    jump = flags.accept;
      COND_SCAN_DONE: jump = flags.scan_done;
      COND_SLOT_FREE: jump = flags.slot_free;
      default:        jump = 1'b1;
    endcase
    pc_next = jump ? uw.target : pc;
  end

  // Advance the step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= PC_IDLE;
    end else begin
      pc <= pc_next;
    end
  end
endmodule

/* rtl/core/hba_checker.sv */
// Port-level checks for the heap block allocator, bound to the top level.
// Depends on hba_pkg for widths and status codes.
module hba_checker
  import hba_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                req_valid,
  input logic                req_ready,
  input logic                rsp_valid,
  input logic                rsp_ready,
  input logic [ADDR_W-1:0]   rsp_addr,
  input logic [STATUS_W-1:0] rsp_status
);
  // Stalled response holds its payload
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_addr) && $stable(rsp_status))
    else $error("response changed while stalled");

  // Response valid drops only after it was taken
  a_rsp_drop: assert property (@(posedge clk) disable iff (rst)
    $fell(rsp_valid) |-> $past(rsp_ready))
    else $error("response dropped without handshake");

  // Failed or free responses carry a zero address
  a_zero_addr: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != ST_REUSED && rsp_status != ST_GROWN |-> rsp_addr == '0)
    else $error("non-allocation response carries an address");

  // Requests are taken one at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while another is in progress");

  // Reset leaves no response pending
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid after reset");
endmodule

bind heap_block_allocator_top hba_checker u_hba_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .rsp_addr   (rsp.result_address),
  .rsp_status (rsp.status)
);

/* dv/tb_heap_block_allocator_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for heap_block_allocator_top: a queue-fed request driver,
// a response monitor and an in-bench allocator predictor, over several register settings.
// Depends on hba_pkg, hba_if and the allocator RTL.
module tb_heap_block_allocator_top;
  import hba_pkg::*;

  localparam int TABLE_DEPTH = DEF_MAX_BLOCKS;
  localparam int HDR_BYTES = DEF_HEADER_BYTES;
  localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 80;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [REQ_W-1:0]  request_size;
    logic [ADDR_W-1:0] user_address;
  } heap_req_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   result_address;
    logic [STATUS_W-1:0] status;
  } heap_reply_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  hba_req_if req_ch ();
  hba_rsp_if rsp_ch ();

  heap_block_allocator_top dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Predicted allocator state
  logic [31:0]       cfg_base;
  logic [31:0]       cfg_limit;
  logic [OFF_W-1:0]  tbl_off  [0:TABLE_DEPTH-1];
  logic [SIZE_W-1:0] tbl_size [0:TABLE_DEPTH-1];
  bit                tbl_free [0:TABLE_DEPTH-1];
  int                tbl_count;
  logic [31:0]       used_bytes;

  heap_req_t   pending_reqs[$];
  heap_reply_t expected_replies[$];
  heap_req_t   drive_item;
  heap_reply_t front_reply;
  heap_reply_t new_reply;
  logic        req_taken;
  int          idle_pct;
  int          stall_pct;
  int          n_issued;
  int          n_taken;
  int          errors;
  int          quiet_cycles;

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [31:0] block_user_addr(input int idx);
    return cfg_base + tbl_off[idx] + 32'(HDR_BYTES);
  endfunction

  // Apply one request to the predicted table and return the reply it earns
  function automatic heap_reply_t heap_apply(input heap_req_t r);
    heap_reply_t rep;
    logic [31:0] total;
    logic [31:0] spare;
    logic [31:0] best_spare;
    bit          found;
    int          pick;
    int          i;
    rep.result_address = '0;
    rep.status = ST_BAD_FREE;
    if (r.command == CMD_FIRST_FIT || r.command == CMD_BEST_FIT) begin
      total = 32'(r.request_size) + 32'(HDR_BYTES);
      found = 1'b0;
      pick = 0;
      best_spare = '0;
      i = 0;
      // scan free blocks; first fit stops at the first hit
      while (i < tbl_count && !(found && r.command == CMD_FIRST_FIT)) begin
        if (tbl_free[i] && 32'(tbl_size[i]) >= total) begin
          spare = 32'(tbl_size[i]) - total;
          if (!found || (r.command == CMD_BEST_FIT && spare < best_spare)) begin
            found = 1'b1;
            pick = i;
            best_spare = spare;
          end
        end
        i++;
      end
      if (found) begin
        tbl_free[pick] = 1'b0;
        rep.result_address = block_user_addr(pick);
        rep.status = ST_REUSED;
      end else if (tbl_count >= TABLE_DEPTH ||
                   ({1'b0, used_bytes} + {1'b0, total}) > {1'b0, cfg_limit}) begin
        rep.status = ST_NO_SPACE;
      end else begin
        // append at the heap end
        tbl_off[tbl_count] = used_bytes;
        tbl_size[tbl_count] = total[SIZE_W-1:0];
        tbl_free[tbl_count] = 1'b0;
        rep.result_address = block_user_addr(tbl_count);
        used_bytes = used_bytes + total;
        tbl_count++;
        rep.status = ST_GROWN;
      end
    end else if (r.command == CMD_FREE) begin
      found = 1'b0;
      i = 0;
      while (i < tbl_count && !found) begin
        if (block_user_addr(i) == r.user_address) begin
          tbl_free[i] = 1'b1;
          found = 1'b1;
          rep.status = ST_FREED;
        end
        i++;
      end
    end
    return rep;
  endfunction

  // Mostly small sizes, a few medium, a rare full-width one
  function automatic logic [REQ_W-1:0] pick_size();
    int p;
    p = $urandom_range(99);
    if (p < 70) return REQ_W'($urandom_range(48));
    if (p < 90) return REQ_W'($urandom_range(512));
    if (p < 97) return REQ_W'($urandom_range(4095));
    return REQ_W'($urandom);
  endfunction

  // Build one random request from what the table holds so far
  function automatic heap_req_t make_random_request();
    heap_req_t r;
    int        p;
    int        k;
    r.command = CMD_FIRST_FIT;
    r.request_size = REQ_W'($urandom);
    r.user_address = $urandom;
    p = $urandom_range(99);
    k = (tbl_count > 0) ? $urandom_range(tbl_count - 1) : 0;
    if (p < 32) begin
      r.request_size = pick_size();
    end else if (p < 60) begin
      r.command = CMD_BEST_FIT;
      r.request_size = pick_size();
    end else if (p < 68) begin
      // exact fit for a known block
      r.command = $urandom_range(1) ? CMD_BEST_FIT : CMD_FIRST_FIT;
      if (tbl_count > 0) r.request_size = REQ_W'(tbl_size[k] - SIZE_W'(HDR_BYTES));
    end else if (p < 92) begin
      r.command = CMD_FREE;
      if (tbl_count > 0) r.user_address = block_user_addr(k);
    end else if (p < 96) begin
      // near miss on a real address
      r.command = CMD_FREE;
      if (tbl_count > 0) r.user_address = block_user_addr(k) + 32'($urandom_range(1, 7));
    end else if (p < 98) begin
      r.command = CMD_FREE;
    end else begin
      r.command = CMD_RESERVED;
    end
    return r;
  endfunction

  task automatic push_req(input logic [CMD_W-1:0] cmd, input logic [REQ_W-1:0] size,
                          input logic [ADDR_W-1:0] addr);
    pending_reqs.push_back('{command: cmd, request_size: size, user_address: addr});
    n_issued++;
  endtask

  // Register write at the falling edge, taken at the next rising edge
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    if (idx == CFG_HEAP_BASE) cfg_base = data;
    else cfg_limit = data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    while (n_taken != n_issued || expected_replies.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic run_random(input int send_idle, input int rsp_stall,
                            input logic [31:0] base, input logic [31:0] limit,
                            input int count);
    int made;
    wait_idle();
    write_reg(CFG_HEAP_BASE, base);
    write_reg(CFG_HEAP_LIMIT, limit);
    idle_pct = send_idle;
    stall_pct = rsp_stall;
    made = 0;
    // keep a few items queued ahead of the driver
    while (made < count) begin
      @(negedge clk);
      if (pending_reqs.size() < 3) begin
        pending_reqs.push_back(make_random_request());
        n_issued++;
        made++;
      end
    end
  endtask

  // Request driver: advance after each accepted item, idle at random
  always @(negedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_taken) begin
      if (pending_reqs.size() != 0 && $urandom_range(99) >= idle_pct) begin
        drive_item = pending_reqs.pop_front();
        req_ch.valid <= 1'b1;
        req_ch.command <= drive_item.command;
        req_ch.request_size <= drive_item.request_size;
        req_ch.user_address <= drive_item.user_address;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Response side: stall at random
  always @(negedge clk) begin
    rsp_ch.ready <= !rst && ($urandom_range(99) >= stall_pct);
  end

  // Monitor: predict on each request, check each response, watch for a hang
  always @(posedge clk) begin
    if (rst) begin
      req_taken <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      req_taken <= req_ch.valid && req_ch.ready;
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_replies.size() == 0) begin
          $error("response item with nothing expected: result_address %h status %0d",
                 rsp_ch.result_address, rsp_ch.status);
          errors++;
        end else begin
          front_reply = expected_replies.pop_front();
          if (rsp_ch.result_address !== front_reply.result_address) begin
            $error("result_address: expected %h, got %h",
                   front_reply.result_address, rsp_ch.result_address);
            errors++;
          end
          if (rsp_ch.status !== front_reply.status) begin
            $error("status: expected %0d, got %0d", front_reply.status, rsp_ch.status);
            errors++;
          end
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        new_reply = heap_apply('{command: req_ch.command, request_size: req_ch.request_size,
                                 user_address: req_ch.user_address});
        expected_replies.push_back(new_reply);
        n_taken++;
      end
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_HEAP_BASE;
    cfg_wdata = '0;
    req_ch.valid = 1'b0;
    req_ch.command = CMD_FIRST_FIT;
    req_ch.request_size = '0;
    req_ch.user_address = '0;
    rsp_ch.ready = 1'b0;
    cfg_base = '0;
    cfg_limit = HEAP_LIMIT_RESET;
    tbl_count = 0;
    used_bytes = '0;
    idle_pct = 0;
    stall_pct = 0;
    n_issued = 0;
    n_taken = 0;
    errors = 0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: growth, frees, reuse and the heap limit on a fresh table
    write_reg(CFG_HEAP_BASE, 32'h0000_1000);
    write_reg(CFG_HEAP_LIMIT, 32'd200);
    push_req(CMD_FIRST_FIT, 24'd0, '0);              // zero request
    push_req(CMD_BEST_FIT, 24'd16, '0);
    push_req(CMD_FIRST_FIT, 24'd24, '0);
    push_req(CMD_FREE, '0, 32'h0000_1008);
    push_req(CMD_FREE, '0, 32'h0000_1008);           // double free
    push_req(CMD_FREE, '0, 32'h0000_1009);           // unmatched
    push_req(CMD_FREE, 24'hFF_FFFF, 32'hFFFF_FFFF);  // unmatched
    push_req(CMD_RESERVED, 24'd5, 32'h0000_1010);
    push_req(CMD_FREE, '0, 32'h0000_1010);
    push_req(CMD_FREE, '0, 32'h0000_1028);
    push_req(CMD_BEST_FIT, 24'd10, '0);              // least spare among the free blocks
    push_req(CMD_FIRST_FIT, 24'd0, '0);
    push_req(CMD_FIRST_FIT, 24'd20, 32'hFFFF_FFFF);
    push_req(CMD_BEST_FIT, 24'hFF_FFFF, '0);         // past the limit
    push_req(CMD_FIRST_FIT, 24'd128, '0);            // lands exactly on the limit
    push_req(CMD_FIRST_FIT, 24'd0, '0);
    push_req(CMD_BEST_FIT, 24'd0, '0);

    // Random phases across idling patterns and register extremes
    run_random(0, 0, 32'hFFFF_FF00, 32'd2000, 250);
    run_random(82, 0, 32'h0000_0000, 32'h0000_0000, 250);
    run_random(0, 82, 32'h8000_0000, 32'hFFFF_FFFF, 250);
    run_random(20, 20, 32'hFFFF_FFFF, HEAP_LIMIT_RESET, 250);

    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (expected_replies.size() != 0) begin
      $error("%0d response items never arrived", expected_replies.size());
      errors++;
    end
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
